@@ rtl/core/lrts_pkg.sv @@
`timescale 1ns / 1ps

package lrts_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = 4;
    localparam int TIME_W = 16;
    localparam int CNT_W  = 5;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Running best candidate handed from cell to cell
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] idx;
        logic [TIME_W-1:0] rem;
        logic [TIME_W-1:0] arr;
        logic [TIME_W-1:0] bur;
    } cand_t;

    // Broadcast from the sequencer to every cell
    typedef struct packed {
        logic              load_en;
        logic              dec_en;
        logic [SLOT_W-1:0] sel_slot;
        logic [TIME_W-1:0] arr;
        logic [TIME_W-1:0] bur;
        logic [TIME_W-1:0] now;
        logic [CNT_W-1:0]  live_count;
    } cell_ctrl_t;

endpackage

@@ rtl/core/longest_remaining_time_scheduler_top.sv @@
`timescale 1ns / 1ps
// Flow: a load writes its slot cell (ST_LOAD), then registers its result (ST_RESULT);
// a tick ripples the candidate through the row of slot cells (ST_SCAN), commits the
// decrement and time step (ST_COMMIT), then registers the result (ST_RESULT).
// One item at a time: a new item is taken only after the last result is registered.
// Reset: async active low; clears time, all remaining counts and active_count.

module longest_remaining_time_scheduler_top
    import lrts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,      // active_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,       // slot[3:0], arrival[19:4], burst[35:20]
    input  logic        s_tuser,       // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata        // ran_slot[3:0], busy_res[4], finished[5],
                                       // turnaround[21:6], waiting[37:22],
                                       // all_done[38], time_now[54:39]
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LOAD   = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_COMMIT = 5'b01000,
        ST_RESULT = 5'b10000
    } state_t;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] cnt_reg;
    logic [CNT_W-1:0]  active_reg;
    logic [TIME_W-1:0] time_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [TIME_W-1:0] arr_reg;
    logic [TIME_W-1:0] bur_reg;
    logic [SLOT_W-1:0] ran_reg;
    logic              busy_reg;
    logic              fin_reg;
    logic [TIME_W-1:0] tat_reg;
    logic [TIME_W-1:0] cbur_reg;
    logic              out_valid_reg;
    logic [55:0]       out_data_reg;

    cand_t             chain [SLOTS+1];
    logic [SLOTS-1:0]  pend;
    cell_ctrl_t        ctrl;
    cand_t             best;
    logic [TIME_W-1:0] time_inc;
    logic [TIME_W-1:0] tat_new;
    logic [TIME_W-1:0] wt;
    logic              out_free;
    logic              in_xfer;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign best      = chain[SLOTS];
    assign time_inc  = (time_reg == TIME_MAX) ? time_reg : time_reg + 1'b1;
    assign tat_new   = time_inc - best.arr;
    assign wt        = (tat_reg >= cbur_reg) ? tat_reg - cbur_reg : '0;

    always_comb
    begin
        ctrl.load_en    = (state_reg == ST_LOAD);
        ctrl.dec_en     = (state_reg == ST_COMMIT) && best.found;
        ctrl.sel_slot   = (state_reg == ST_LOAD) ? slot_reg : best.idx;
        ctrl.arr        = arr_reg;
        ctrl.bur        = bur_reg;
        ctrl.now        = time_reg;
        ctrl.live_count = active_reg;
    end

    assign chain[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++)
        begin : g_cell
            lrts_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .slot_id  (SLOT_W'(gi)),
                .ctrl     (ctrl),
                .cand_in  (chain[gi]),
                .cand_out (chain[gi+1]),
                .pending  (pend[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = (s_tuser == OP_TICK) ? ST_SCAN : ST_LOAD;
                end
            end
            ST_LOAD:   state_next = ST_RESULT;
            ST_SCAN:
            begin
                if (cnt_reg == SLOT_W'(SLOTS - 1))
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: state_next = ST_RESULT;
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            active_reg    <= '0;
            time_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                active_reg <= cfg_data;
            end
            if (state_reg == ST_SCAN)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end
            if (state_reg == ST_COMMIT)
            begin
                time_reg <= time_inc;
            end
            if (state_reg == ST_RESULT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            slot_reg <= s_tdata[3:0];
            arr_reg  <= s_tdata[19:4];
            bur_reg  <= s_tdata[35:20];
        end
        case (state_reg)
            ST_LOAD:
            begin
                ran_reg  <= '0;
                busy_reg <= 1'b0;
                fin_reg  <= 1'b0;
                tat_reg  <= '0;
                cbur_reg <= '0;
            end
            ST_COMMIT:
            begin
                ran_reg  <= best.found ? best.idx : '0;
                busy_reg <= best.found;
                fin_reg  <= best.found && (best.rem == TIME_W'(1));
                tat_reg  <= (best.found && (best.rem == TIME_W'(1))) ? tat_new : '0;
                cbur_reg <= best.bur;
            end
            default:
            begin
            end
        endcase
        if (state_reg == ST_RESULT && out_free)
        begin
            out_data_reg <= {1'b0, time_reg, ~|pend, wt, tat_reg, fin_reg, busy_reg,
                             ran_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tdata[5] || m_tdata[4]))
        else $error("finished reported without a slot running");

    a_commit_time: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT) |=> (time_reg >= $past(time_reg)))
        else $error("time went backwards on commit");

    a_ran_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT && best.found) |-> ({1'b0, best.idx} < active_reg))
        else $error("chosen slot outside active range");

    a_scan_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT) |-> ($past(cnt_reg) == SLOT_W'(SLOTS - 1)))
        else $error("commit reached before the scan completed");

endmodule

@@ rtl/core/lrts_cell.sv @@
`timescale 1ns / 1ps

module lrts_cell
    import lrts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SLOT_W-1:0] slot_id,
    input  cell_ctrl_t        ctrl,
    input  cand_t             cand_in,
    output cand_t             cand_out,
    output logic              pending
);

    logic [TIME_W-1:0] rem_reg;
    logic [TIME_W-1:0] arr_reg;
    logic [TIME_W-1:0] bur_reg;
    cand_t             cand_reg;
    cand_t             cand_next;
    logic              live;
    logic              eligible;
    logic              take;
    logic              hit;

    assign hit      = (ctrl.sel_slot == slot_id);
    assign live     = ({1'b0, slot_id} < ctrl.live_count);
    assign eligible = live && (rem_reg != '0) && (arr_reg <= ctrl.now);
    // earlier cells win ties on both keys, so strict compares here
    assign take     = eligible && (!cand_in.found || (rem_reg > cand_in.rem) ||
                      ((rem_reg == cand_in.rem) && (arr_reg < cand_in.arr)));
    assign pending  = live && (rem_reg != '0);

    always_comb
    begin
        cand_next = cand_in;
        if (take)
        begin
            cand_next.found = 1'b1;
            cand_next.idx   = slot_id;
            cand_next.rem   = rem_reg;
            cand_next.arr   = arr_reg;
            cand_next.bur   = bur_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            cand_reg <= '0;
        end
        else
        begin
            cand_reg <= cand_next;
            if (ctrl.load_en && hit)
            begin
                rem_reg <= ctrl.bur;
            end
            else if (ctrl.dec_en && hit)
            begin
                rem_reg <= rem_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_en && hit)
        begin
            arr_reg <= ctrl.arr;
            bur_reg <= ctrl.bur;
        end
    end

    assign cand_out = cand_reg;

endmodule

@@ test/tb_longest_remaining_time_scheduler_top.sv @@
`timescale 1ns / 1ps

module tb_longest_remaining_time_scheduler_top;

    import lrts_pkg::*;

    localparam int CYCLE_LIMIT = 6_000_000;
    localparam logic [TIME_W-1:0] TIME_TOP = '1;

    // one result word as it leaves on m_tdata, lowest field last
    typedef struct packed {
        logic              pad;
        logic [TIME_W-1:0] time_now;
        logic              all_done;
        logic [TIME_W-1:0] waiting;
        logic [TIME_W-1:0] turnaround;
        logic              finished;
        logic              busy;
        logic [SLOT_W-1:0] ran_slot;
    } sched_res_t;

    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

    typedef struct packed {
        row_kind_e         kind;
        logic              op;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] arr;
        logic [TIME_W-1:0] bur;
        logic [CNT_W-1:0]  cfg;
        logic              typed;
        sched_res_t        want;
    } stim_row_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    // scheduler image kept by the testbench
    logic [CNT_W-1:0]  live_cnt = '0;
    logic [TIME_W-1:0] sched_now = '0;
    logic [TIME_W-1:0] rem_left [SLOTS];
    logic [TIME_W-1:0] arr_at [SLOTS];
    logic [TIME_W-1:0] burst_len [SLOTS];

    sched_res_t pending_results [$];
    sched_res_t last_pred;
    stim_row_t  dir_rows [$];

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic send_quiet = 1'b0;
    logic recv_quiet = 1'b0;
    int   items_sent = 0;
    int   mismatches = 0;
    int   cycles = 0;

    longest_remaining_time_scheduler_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_longest_remaining_time_scheduler_top NOT OK");
            $finish;
        end
    end

    function automatic sched_res_t lrtf_step(input logic op, input logic [SLOT_W-1:0] sl,
                                             input logic [TIME_W-1:0] at,
                                             input logic [TIME_W-1:0] bt);
        sched_res_t        r;
        int                n;
        int                best;
        logic              found;
        logic [TIME_W-1:0] tat;
        r = '0;
        n = (live_cnt > SLOTS) ? SLOTS : int'(live_cnt);
        if (op == OP_LOAD)
        begin
            arr_at[sl] = at;
            burst_len[sl] = bt;
            rem_left[sl] = bt;
        end
        else
        begin
            found = 1'b0;
            best = 0;
            for (int i = 0; i < n; i++)
            begin
                if (rem_left[i] != '0 && arr_at[i] <= sched_now)
                begin
                    if (!found || rem_left[i] > rem_left[best] ||
                        (rem_left[i] == rem_left[best] && arr_at[i] < arr_at[best]))
                    begin
                        best = i;
                        found = 1'b1;
                    end
                end
            end
            if (sched_now != TIME_TOP)
                sched_now = sched_now + 1'b1;
            if (found)
            begin
                r.busy = 1'b1;
                r.ran_slot = SLOT_W'(best);
                rem_left[best] = rem_left[best] - 1'b1;
                if (rem_left[best] == '0)
                begin
                    // after saturation turnaround may undercut the burst
                    tat = sched_now - arr_at[best];
                    r.finished = 1'b1;
                    r.turnaround = tat;
                    r.waiting = (tat >= burst_len[best]) ? tat - burst_len[best] : '0;
                end
            end
        end
        r.all_done = 1'b1;
        for (int i = 0; i < n; i++)
            if (rem_left[i] != '0)
                r.all_done = 1'b0;
        r.time_now = sched_now;
        return r;
    endfunction

    function automatic sched_res_t quiet_res(input logic [TIME_W-1:0] t);
        sched_res_t r;
        r = '0;
        r.all_done = 1'b1;
        r.time_now = t;
        return r;
    endfunction

    function automatic stim_row_t make_row(input row_kind_e kind, input logic op,
                                           input logic [SLOT_W-1:0] sl,
                                           input logic [TIME_W-1:0] at,
                                           input logic [TIME_W-1:0] bt,
                                           input logic [CNT_W-1:0] cfg,
                                           input logic typed, input sched_res_t want);
        stim_row_t row;
        row.kind = kind;
        row.op = op;
        row.slot = sl;
        row.arr = at;
        row.bur = bt;
        row.cfg = cfg;
        row.typed = typed;
        row.want = want;
        return row;
    endfunction

    task automatic send_item(input logic op, input logic [SLOT_W-1:0] sl,
                             input logic [TIME_W-1:0] at, input logic [TIME_W-1:0] bt,
                             input logic typed = 1'b0, input sched_res_t want = '0);
        sched_res_t pred;
        if (!send_quiet && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, bt, at, sl};
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
        pred = lrtf_step(op, sl, at, bt);
        pending_results.push_back(typed ? want : pred);
        last_pred = pred;
        items_sent++;
    endtask

    // only called right after a transfer or with the input side idle
    task automatic write_active(input logic [CNT_W-1:0] v);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        live_cnt = v;
    endtask

    task automatic send_load();
        logic [TIME_W-1:0] at;
        logic [TIME_W-1:0] bt;
        int                r;
        r = $urandom_range(19);
        if (r < 15)
            at = sched_now + TIME_W'($urandom_range(0, 6));
        else if (r < 18)
            at = (sched_now > 20) ? sched_now - TIME_W'($urandom_range(1, 20)) : '0;
        else
            at = TIME_W'($urandom);
        r = $urandom_range(19);
        if (r < 15)
            bt = TIME_W'($urandom_range(1, 10));
        else if (r < 17)
            bt = '0;
        else if (r < 19)
            bt = TIME_W'($urandom_range(11, 300));
        else
            bt = TIME_W'($urandom);
        send_item(OP_LOAD, SLOT_W'($urandom_range(SLOTS - 1)), at, bt);
    endtask

    // reconfigure, load a few slots, then mostly ticks with loads mixed in
    task automatic run_batch();
        logic [CNT_W-1:0] act;
        case ($urandom_range(9))
            0:       act = '0;
            1:       act = CNT_W'(SLOTS);
            2:       act = CNT_W'($urandom_range(SLOTS + 1, 31));
            default: act = CNT_W'($urandom_range(1, SLOTS - 1));
        endcase
        write_active(act);
        send_quiet = ($urandom_range(3) == 0);
        recv_quiet = ($urandom_range(3) == 0);
        repeat ($urandom_range(1, 6)) send_load();
        repeat ($urandom_range(4, 30))
        begin
            if ($urandom_range(9) == 0)
                send_load();
            else
                send_item(OP_TICK, SLOT_W'($urandom), TIME_W'($urandom), TIME_W'($urandom));
        end
    endtask

    always @(posedge clk)
    begin
        sched_res_t got;
        sched_res_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = sched_res_t'(m_tdata);
            if (pending_results.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result at cycle %0d: %h", cycles, m_tdata);
                mismatches++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (got.ran_slot !== exp_r.ran_slot || got.busy !== exp_r.busy ||
                    got.finished !== exp_r.finished ||
                    got.turnaround !== exp_r.turnaround ||
                    got.waiting !== exp_r.waiting || got.all_done !== exp_r.all_done ||
                    got.time_now !== exp_r.time_now)
                begin
                    if (mismatches < 10)
                        $display("mismatch at cycle %0d: exp slot=%0d busy=%b fin=%b tat=%0d",
                                 cycles, exp_r.ran_slot, exp_r.busy, exp_r.finished,
                                 exp_r.turnaround, " wt=%0d done=%b now=%0d",
                                 exp_r.waiting, exp_r.all_done, exp_r.time_now,
                                 " | got slot=%0d busy=%b fin=%b tat=%0d", got.ran_slot,
                                 got.busy, got.finished, got.turnaround,
                                 " wt=%0d done=%b now=%0d", got.waiting, got.all_done,
                                 got.time_now);
                    mismatches++;
                end
            end
        end
        m_tready <= recv_quiet || ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        int base;
        int wait_cnt;

        for (int i = 0; i < SLOTS; i++)
        begin
            rem_left[i] = '0;
            arr_at[i] = '0;
            burst_len[i] = '0;
        end

        // every slot is loaded before any slot becomes active
        dir_rows.push_back(make_row(ROW_CFG, OP_LOAD, 0, 0, 0, 0, 1'b0, '0));
        dir_rows.push_back(make_row(ROW_ITEM, OP_TICK, 4'hF, 16'hFFFF, 16'hFFFF, 0,
                                    1'b1, quiet_res(1)));
        dir_rows.push_back(make_row(ROW_ITEM, OP_LOAD, 0, 0, 2, 0, 1'b1, quiet_res(1)));
        dir_rows.push_back(make_row(ROW_ITEM, OP_LOAD, 1, 0, 2, 0, 1'b1, quiet_res(1)));
        dir_rows.push_back(make_row(ROW_ITEM, OP_LOAD, 2, 1, 3, 0, 1'b1, quiet_res(1)));
        dir_rows.push_back(make_row(ROW_ITEM, OP_LOAD, 3, 0, 0, 0, 1'b1, quiet_res(1)));
        dir_rows.push_back(make_row(ROW_ITEM, OP_LOAD, 4, 2, 3, 0, 1'b1, quiet_res(1)));
        dir_rows.push_back(make_row(ROW_ITEM, OP_LOAD, 5, 16'hFFFF, 16'hFFFF, 0, 1'b1,
                                    quiet_res(1)));
        for (int s = 6; s < SLOTS - 1; s++)
            dir_rows.push_back(make_row(ROW_ITEM, OP_LOAD, SLOT_W'(s), 16'hFFFF,
                                        TIME_W'(s), 0, 1'b1, quiet_res(1)));
        dir_rows.push_back(make_row(ROW_ITEM, OP_LOAD, 4'hF, 16'h8000, 1, 0, 1'b1,
                                    quiet_res(1)));
        // 31 behaves as all sixteen slots
        dir_rows.push_back(make_row(ROW_CFG, OP_LOAD, 0, 0, 0, 5'd31, 1'b0, '0));
        repeat (8)
            dir_rows.push_back(make_row(ROW_ITEM, OP_TICK, 0, 0, 0, 0, 1'b0, '0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[k])
        begin
            if (dir_rows[k].kind == ROW_CFG)
                write_active(dir_rows[k].cfg);
            else
                send_item(dir_rows[k].op, dir_rows[k].slot, dir_rows[k].arr,
                          dir_rows[k].bur, dir_rows[k].typed, dir_rows[k].want);
        end

        base = items_sent;
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 64 : 0;
            recv_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 10 : 0;
            while (items_sent - base < (ph + 1) * 567)
                run_batch();
        end

        // two short jobs run down to completion
        write_active(2);
        send_item(OP_LOAD, 0, sched_now, 16'd5);
        send_item(OP_LOAD, 1, sched_now + 16'd1, 16'd3);
        do send_item(OP_TICK, 0, 0, 0); while (!last_pred.all_done);

        s_tvalid <= 1'b0;
        wait_cnt = 0;
        while (pending_results.size() != 0 && wait_cnt < 20000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (25) @(posedge clk);
        mismatches += pending_results.size();
        if (mismatches == 0)
            $display("tb_longest_remaining_time_scheduler_top OK");
        else
            $display("tb_longest_remaining_time_scheduler_top NOT OK");
        $finish;
    end

endmodule

@@ longest_remaining_time_scheduler_top.f @@
rtl/core/lrts_pkg.sv
rtl/core/lrts_cell.sv
rtl/core/longest_remaining_time_scheduler_top.sv
test/tb_longest_remaining_time_scheduler_top.sv
